### design/tmvp_pkg.sv
// ----------------------------------------------------------------------------
// tmvp_pkg
// Shared types and constants of the tridiagonal matrix-vector product block:
// the job that the front end hands to the arithmetic back end, and the size
// of the queue that separates them.
// ----------------------------------------------------------------------------
package tmvp_pkg;

  localparam int COEF_W   = 16;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ROWIDX_W = 10;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One accepted item, already classified. Terms that are dropped carry a
  // zero coefficient, so the back end simply adds every product.
  typedef struct packed {
    logic                     has_a;   // result of the held row
    logic                     has_b;   // result of the final row
    logic signed [COEF_W-1:0] a_coef_lo;
    logic signed [COEF_W-1:0] a_coef_dg;
    logic signed [COEF_W-1:0] a_coef_up;
    logic signed [COEF_W-1:0] a_x_lo;
    logic signed [COEF_W-1:0] a_x_dg;
    logic signed [COEF_W-1:0] a_x_up;
    logic signed [COEF_W-1:0] b_coef_lo;
    logic signed [COEF_W-1:0] b_coef_dg;
    logic signed [COEF_W-1:0] b_x_lo;
    logic signed [COEF_W-1:0] b_x_dg;
    logic [ROWIDX_W-1:0]      row_a;
    logic [ROWIDX_W-1:0]      row_b;
  } tmvp_job_t;

endpackage

### design/tmvp_front.sv
// ----------------------------------------------------------------------------
// tmvp_front
// Accepts vector rows, keeps the held row and the two previous vector
// elements, and turns each beat into a job for the back end (or into
// nothing when the beat only starts a vector).
// ----------------------------------------------------------------------------
module tmvp_front #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic signed [15:0]         x_value,
  input  logic signed [15:0]         coef_lower,
  input  logic signed [15:0]         coef_diag,
  input  logic signed [15:0]         coef_upper,
  input  logic                       is_last,
  output logic                       push,
  output tmvp_pkg::tmvp_job_t        push_job,
  input  logic                       queue_full
);
  import tmvp_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic signed [COEF_W-1:0] held_lower;
  logic signed [COEF_W-1:0] held_diag;
  logic signed [COEF_W-1:0] held_upper;
  logic signed [COEF_W-1:0] x_previous;
  logic signed [COEF_W-1:0] x_before_previous;
  logic                     row_pending;
  logic [RW-1:0]            row_counter;

  logic                     accept;
  logic [RW-1:0]            next_row;
  logic [RW+ROWIDX_W-1:0]   row_a_wide;
  logic [RW+ROWIDX_W-1:0]   row_b_wide;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;

  // Number of the row after the held one, wrapping at the row limit
  always_comb begin
    if (!row_pending) begin
      next_row = '0;
    end else if (row_counter == RW'(MAX_ROWS - 1)) begin
      next_row = '0;
    end else begin
      next_row = row_counter + 1'b1;
    end
  end

  assign row_a_wide = {{ROWIDX_W{1'b0}}, row_counter};
  assign row_b_wide = {{ROWIDX_W{1'b0}}, next_row};

  // Build the job; a row numbered zero drops its lower term
  always_comb begin
    push_job.has_a     = row_pending;
    push_job.has_b     = is_last;
    push_job.a_coef_lo = (row_counter != '0) ? held_lower : '0;
    push_job.a_coef_dg = held_diag;
    push_job.a_coef_up = held_upper;
    push_job.a_x_lo    = x_before_previous;
    push_job.a_x_dg    = x_previous;
    push_job.a_x_up    = x_value;
    push_job.b_coef_lo = (next_row != '0) ? coef_lower : '0;
    push_job.b_coef_dg = coef_diag;
    push_job.b_x_lo    = x_previous;
    push_job.b_x_dg    = x_value;
    push_job.row_a     = row_a_wide[ROWIDX_W-1:0];
    push_job.row_b     = row_b_wide[ROWIDX_W-1:0];
  end

  // Only beats that yield a result go to the queue
  assign push = accept && (row_pending || is_last);

  // Advance the held row, or clear everything at the end of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lower        <= '0;
      held_diag         <= '0;
      held_upper        <= '0;
      x_previous        <= '0;
      x_before_previous <= '0;
      row_pending       <= 1'b0;
      row_counter       <= '0;
    end else if (accept) begin
      if (is_last) begin
        held_lower        <= '0;
        held_diag         <= '0;
        held_upper        <= '0;
        x_previous        <= '0;
        x_before_previous <= '0;
        row_pending       <= 1'b0;
        row_counter       <= '0;
      end else begin
        held_lower        <= coef_lower;
        held_diag         <= coef_diag;
        held_upper        <= coef_upper;
        x_previous        <= x_value;
        x_before_previous <= row_pending ? x_previous : '0;
        row_pending       <= 1'b1;
        row_counter       <= next_row;
      end
    end
  end

endmodule

### design/tmvp_queue.sv
// ----------------------------------------------------------------------------
// tmvp_queue
// Short first-in first-out queue of jobs between the front and back ends,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tmvp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tmvp_pkg::tmvp_job_t push_job,
  output logic                full,
  output logic                head_valid,
  output tmvp_pkg::tmvp_job_t head_job,
  input  logic                pop
);
  import tmvp_pkg::*;

  tmvp_job_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/tmvp_back.sv
// ----------------------------------------------------------------------------
// tmvp_back
// Arithmetic back end: multiplies the terms of a job into a product
// register, then adds them into the result register, one result a beat while result_stall is low.
// ----------------------------------------------------------------------------
module tmvp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  tmvp_pkg::tmvp_job_t                  head_job,
  output logic                                 pop,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [tmvp_pkg::SUM_W-1:0]    product_value,
  output logic [tmvp_pkg::ROWIDX_W-1:0]        row_index,
  output logic                                 last_result
);
  import tmvp_pkg::*;

  logic                     s1_valid;
  logic                     s1_has_a;
  logic                     s1_has_b;
  logic signed [PROD_W-1:0] pa_lo;
  logic signed [PROD_W-1:0] pa_dg;
  logic signed [PROD_W-1:0] pa_up;
  logic signed [PROD_W-1:0] pb_lo;
  logic signed [PROD_W-1:0] pb_dg;
  logic [ROWIDX_W-1:0]      s1_row_a;
  logic [ROWIDX_W-1:0]      s1_row_b;

  logic                     out_ready;
  logic                     s1_done;
  logic                     s1_load;
  logic signed [SUM_W-1:0]  sum_a;
  logic signed [SUM_W-1:0]  sum_b;

  assign out_ready = !result_valid || !result_stall;
  // The product register empties once its last pending result leaves
  assign s1_done   = s1_valid && out_ready && !(s1_has_a && s1_has_b);
  assign s1_load   = !s1_valid || s1_done;
  assign pop       = s1_load && head_valid;

  // Sign-extend the products and add them
  assign sum_a = $signed({pa_lo[PROD_W-1], pa_lo}) + $signed({pa_dg[PROD_W-1], pa_dg})
               + $signed({pa_up[PROD_W-1], pa_up});
  assign sum_b = $signed({pb_lo[PROD_W-1], pb_lo}) + $signed({pb_dg[PROD_W-1], pb_dg});

  // Product stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_has_a <= 1'b0;
      s1_has_b <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= head_valid;
      s1_has_a <= head_job.has_a;
      s1_has_b <= head_job.has_b;
    end else if (s1_valid && out_ready && s1_has_a) begin
      s1_has_a <= 1'b0;
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      pa_lo    <= PROD_W'($signed(head_job.a_coef_lo) * $signed(head_job.a_x_lo));
      pa_dg    <= PROD_W'($signed(head_job.a_coef_dg) * $signed(head_job.a_x_dg));
      pa_up    <= PROD_W'($signed(head_job.a_coef_up) * $signed(head_job.a_x_up));
      pb_lo    <= PROD_W'($signed(head_job.b_coef_lo) * $signed(head_job.b_x_lo));
      pb_dg    <= PROD_W'($signed(head_job.b_coef_dg) * $signed(head_job.b_x_dg));
      s1_row_a <= head_job.row_a;
      s1_row_b <= head_job.row_b;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s1_valid;
    end
  end

  // Result register payload: held row first, final row after it
  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      if (s1_has_a) begin
        product_value <= sum_a;
        row_index     <= s1_row_a;
        last_result   <= 1'b0;
      end else begin
        product_value <= sum_b;
        row_index     <= s1_row_b;
        last_result   <= 1'b1;
      end
    end
  end

endmodule

### design/tridiagonal_matrix_vector_product.sv
// ----------------------------------------------------------------------------
// tridiagonal_matrix_vector_product
// Streaming product of a tridiagonal matrix and a vector, one row a beat.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_stall    | x_value, coef_lower, coef_diag,
//            |                            | coef_upper, is_last
//   result   | result_valid / result_stall| product_value, row_index, last_result
//
// One item is taken every cycle while item_stall is low; a final item that
// also closes a held row yields two results, which leave one after the
// other through the one result register. Each result passes the job queue,
// the product register and the result register; of a pair, the held row's leaves first.
// Reset clears the held row, the four-entry job queue and both back stages.
// item_stall rises only when the job queue is full, which happens only when
// the result side stalls.
// ----------------------------------------------------------------------------
module tridiagonal_matrix_vector_product #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [15:0]                 x_value,
  input  logic signed [15:0]                 coef_lower,
  input  logic signed [15:0]                 coef_diag,
  input  logic signed [15:0]                 coef_upper,
  input  logic                               is_last,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [tmvp_pkg::SUM_W-1:0]  product_value,
  output logic [tmvp_pkg::ROWIDX_W-1:0]      row_index,
  output logic                               last_result
);
  import tmvp_pkg::*;

  logic      push;
  tmvp_job_t push_job;
  logic      queue_full;
  logic      head_valid;
  tmvp_job_t head_job;
  logic      pop;

  // Classify rows and build jobs
  tmvp_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .x_value    (x_value),
    .coef_lower (coef_lower),
    .coef_diag  (coef_diag),
    .coef_upper (coef_upper),
    .is_last    (is_last),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Decouple front and back
  tmvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // Multiply, add and deliver
  tmvp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .product_value (product_value),
    .row_index     (row_index),
    .last_result   (last_result)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming tridiagonal matrix-vector product.
// A queue of row beats (directed corner rows, then random vectors including
// one that wraps the row counter) feeds a clocked driver. Every accepted beat
// updates a local row-sum predictor, which queues the expected results. A
// clocked monitor compares each accepted result, field by field, against the
// oldest expectation. Both sides idle in short random bursts, except in quiet
// spells and in the tail of the run.
// ----------------------------------------------------------------------------
module tb_top;

  import tmvp_pkg::*;

  localparam int RANDOM_BEATS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_BEATS   = 100;

  typedef struct {
    logic signed [COEF_W-1:0] x;
    logic signed [COEF_W-1:0] lo;
    logic signed [COEF_W-1:0] dg;
    logic signed [COEF_W-1:0] up;
    logic                     last;
    bit                       drain;  // hold this beat back until all sums are in
  } row_beat_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [ROWIDX_W-1:0]     row;
    logic                    last;
  } row_sum_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic signed [COEF_W-1:0]   x_value = '0;
  logic signed [COEF_W-1:0]   coef_lower = '0;
  logic signed [COEF_W-1:0]   coef_diag = '0;
  logic signed [COEF_W-1:0]   coef_upper = '0;
  logic                       is_last = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [SUM_W-1:0]    product_value;
  logic [ROWIDX_W-1:0]        row_index;
  logic                       last_result;

  row_beat_t pending_beats[$];
  row_sum_t  row_sums[$];
  int        beats_total;
  int        beats_taken;
  int        fails;
  int        cycles;

  // Predictor state: the held row and the two previous vector elements
  logic signed [COEF_W-1:0] held_lo;
  logic signed [COEF_W-1:0] held_dg;
  logic signed [COEF_W-1:0] held_up;
  logic signed [COEF_W-1:0] x_prev;
  logic signed [COEF_W-1:0] x_prev2;
  logic                     row_held;
  logic [ROWIDX_W-1:0]      held_row;

  tridiagonal_matrix_vector_product DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .x_value       (x_value),
    .coef_lower    (coef_lower),
    .coef_diag     (coef_diag),
    .coef_upper    (coef_upper),
    .is_last       (is_last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .product_value (product_value),
    .row_index     (row_index),
    .last_result   (last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Quiet spells with no idling, and none at all near the end
  function automatic bit quiet_spell();
    return (cycles[8:7] == 2'b11) || (pending_beats.size() < TAIL_BEATS);
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_value();
    logic signed [COEF_W-1:0] v;
    case ($urandom_range(7))
      0: v = -16'sd32768;
      1: v = 16'sd32767;
      2: v = '0;
      default: v = COEF_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_beat(input logic signed [COEF_W-1:0] x, lo, dg, up,
                          input logic last, input bit drain);
    row_beat_t b;
    b.x = x; b.lo = lo; b.dg = dg; b.up = up; b.last = last; b.drain = drain;
    pending_beats.push_back(b);
  endtask

  task automatic add_random_vector(input int rows, input bit drain);
    for (int i = 0; i < rows; i++)
      add_beat(pick_value(), pick_value(), pick_value(), pick_value(),
               i == rows - 1, drain && i == 0);
  endtask

  // Update the row-sum predictor with one accepted beat
  task automatic predict_row_sums(input row_beat_t b);
    longint              acc;
    logic [ROWIDX_W-1:0] next_row;
    row_sum_t            r;
    next_row = '0;
    if (row_held) begin
      acc = longint'(held_dg) * longint'(x_prev) + longint'(held_up) * longint'(b.x);
      // row zero, including one reached by wrapping, has no lower term
      if (held_row != 0)
        acc += longint'(held_lo) * longint'(x_prev2);
      r.sum = acc[SUM_W-1:0]; r.row = held_row; r.last = 1'b0;
      row_sums.push_back(r);
      // row counter wraps at MAX_ROWS, which is 2**ROWIDX_W here
      next_row = held_row + 1'b1;
    end
    if (b.last) begin
      acc = longint'(b.dg) * longint'(b.x);
      if (next_row != 0)
        acc += longint'(b.lo) * longint'(x_prev);
      r.sum = acc[SUM_W-1:0]; r.row = next_row; r.last = 1'b1;
      row_sums.push_back(r);
      held_lo = '0; held_dg = '0; held_up = '0;
      x_prev = '0; x_prev2 = '0; row_held = 1'b0; held_row = '0;
    end else begin
      x_prev2  = row_held ? x_prev : '0;
      x_prev   = b.x;
      held_lo  = b.lo;
      held_dg  = b.dg;
      held_up  = b.up;
      row_held = 1'b1;
      held_row = next_row;
    end
  endtask

  // Driver: present beats, hold a stalled beat, idle in bursts
  int        send_idle;
  row_beat_t send_beat;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_idle = 0;
      held_lo = '0; held_dg = '0; held_up = '0;
      x_prev = '0; x_prev2 = '0; row_held = 1'b0; held_row = '0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_row_sums(send_beat);
        beats_taken++;
      end
      if (item_valid && item_stall) begin
        // hold the stalled beat
      end else if (send_idle > 0) begin
        send_idle--;
        item_valid <= 1'b0;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].drain && row_sums.size() != 0)) begin
        item_valid <= 1'b0;
      end else if (!quiet_spell() && $urandom_range(3) == 0) begin
        send_idle = $urandom_range(2);
        item_valid <= 1'b0;
      end else begin
        send_beat = pending_beats.pop_front();
        item_valid <= 1'b1;
        x_value    <= send_beat.x;
        coef_lower <= send_beat.lo;
        coef_diag  <= send_beat.dg;
        coef_upper <= send_beat.up;
        is_last    <= send_beat.last;
      end
    end
  end

  // Monitor: check accepted results, stall in bursts
  int       recv_stall;
  row_sum_t want;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (row_sums.size() == 0) begin
          $display("%0t: unexpected result sum %0d row %0d last %0b",
                   $time, product_value, row_index, last_result);
          fails++;
        end else begin
          want = row_sums.pop_front();
          if (product_value !== want.sum) begin
            $display("%0t: product_value expected %0d actual %0d",
                     $time, want.sum, product_value);
            fails++;
          end
          if (row_index !== want.row) begin
            $display("%0t: row_index expected %0d actual %0d",
                     $time, want.row, row_index);
            fails++;
          end
          if (last_result !== want.last) begin
            $display("%0t: last_result expected %0b actual %0b",
                     $time, want.last, last_result);
            fails++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_stall <= 1'b1;
      end else if (!quiet_spell() && $urandom_range(3) == 0) begin
        recv_stall = $urandom_range(2);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int budget;
    int rows;
    bit long_done;

    // Single-row vectors: diag times x, with lower and upper ignored
    add_beat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b0);
    add_beat(16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
    // Two rows: first row drops lower, last row drops upper
    add_beat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0);
    add_beat(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1, 1'b0);
    // Three rows at the largest positive sum
    for (int i = 0; i < 3; i++)
      add_beat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, i == 2, 1'b0);
    // Three rows at the most negative sum
    for (int i = 0; i < 3; i++)
      add_beat(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, i == 2, 1'b0);
    // All-zero vector
    add_beat('0, '0, '0, '0, 1'b0, 1'b0);
    add_beat('0, '0, '0, '0, 1'b1, 1'b0);
    // Run of final beats back to back
    for (int i = 0; i < 3; i++)
      add_beat(pick_value(), pick_value(), pick_value(), pick_value(), 1'b1, 1'b0);
    add_random_vector(4, 1'b0);

    // Random vectors, one long enough to wrap the row counter
    budget = RANDOM_BEATS;
    long_done = 0;
    add_random_vector(5, 1'b1);
    budget -= 5;
    while (budget > 0) begin
      if (!long_done && budget < RANDOM_BEATS - 40) begin
        rows = $urandom_range(1030, 1025);
        add_random_vector(rows, 1'b1);
        long_done = 1;
      end else if ($urandom_range(5) == 0) begin
        // noise: random final marks
        rows = $urandom_range(6, 1);
        for (int i = 0; i < rows; i++)
          add_beat(pick_value(), pick_value(), pick_value(), pick_value(),
                   1'($urandom_range(1)), 1'b0);
      end else begin
        rows = $urandom_range(3) == 0 ? $urandom_range(16, 5) : $urandom_range(4, 1);
        add_random_vector(rows, $urandom_range(15) == 0);
      end
      budget -= rows;
    end
    beats_total = pending_beats.size();

    // Hold reset, then let the driver run
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < beats_total) @(posedge clk);
    while (row_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0 && row_sums.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
